@@ rtl/kvt_pkg.sv @@
// Package for the key/value table: item types, action codes, entry layout
// and controller states. No dependencies.
package kvt_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_LOOKUP = 2'd1;
	localparam action_t ACT_DELETE = 2'd2;
	localparam action_t ACT_NONE   = 2'd3;

	localparam logic signed [31:0] NOT_FOUND_VALUE = -32'sd1;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} kvt_req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] result_value;
		logic               status;
	} kvt_rsp_t;

	// One table slot as stored in memory
	typedef struct packed {
		logic               valid;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} kvt_state_t;

endpackage

@@ rtl/key_value_table.sv @@
// Key/value table: each item scans all CAPACITY entries through one memory read port.
// An accepted item passes through the scan and then the done state, which gives the result strobe.
// A new item is taken only in the idle state after that strobe; the scan of the read port sets the pace.
// Reset: a clearing pass marks every entry free, busy stays high.
// Each result shows for one cycle on response_valid; the receiver cannot stall it.
module key_value_table import kvt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  kvt_req_t request,
	output logic     response_valid,
	output kvt_rsp_t response
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW:0] LIMIT = (AW+1)'(CAPACITY);
	localparam logic [AW:0] LAST  = (AW+1)'(CAPACITY - 1);

	kvt_state_t state_q, state_d;
	logic [AW:0]   cnt_q;
	kvt_req_t      req_q;
	logic          chk_s1;
	logic [AW-1:0] idx_s1;
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic signed [31:0] hit_val_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	entry_t        mem_rdata;
	logic          act_ok;

	kvt_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (cnt_q == LAST) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == LIMIT) state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign act_ok = (req_q.action != ACT_NONE);

	// Outputs, memory control and write-back
	always_comb begin
		busy           = 1'b1;
		response_valid = 1'b0;
		mem_re         = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = cnt_q[AW-1:0];
		mem_wdata      = '{valid: 1'b0, key: req_q.key, value: req_q.value};
		response.found        = hit_q && act_ok;
		response.result_value = (hit_q && act_ok) ? hit_val_q : NOT_FOUND_VALUE;
		response.status       = (req_q.action == ACT_INSERT) && !hit_q && !free_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				mem_re = (cnt_q != LIMIT);
			end
			ST_DONE: begin
				response_valid = 1'b1;
				if (req_q.action == ACT_INSERT) begin
					mem_we          = hit_q || free_q;
					mem_waddr       = hit_q ? hit_idx_q : free_idx_q;
					mem_wdata.valid = 1'b1;
				end else if (req_q.action == ACT_DELETE) begin
					mem_we    = hit_q;
					mem_waddr = hit_idx_q;
				end
			end
			default: ;
		endcase
	end

	// Advance state, counter and scan results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			chk_s1  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= mem_re;
			if (state_q == ST_CLEAR) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == ST_IDLE) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				if (mem_re) cnt_q <= cnt_q + 1'b1;
				if (chk_s1) begin
					if (mem_rdata.valid && mem_rdata.key == req_q.key) begin
						hit_q <= 1'b1;
					end
					if (!mem_rdata.valid && !free_q) begin
						free_q <= 1'b1;
					end
				end
			end
		end
	end

	// Hold the item and the payload of the scan
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= request;
		end
		idx_s1 <= cnt_q[AW-1:0];
		if (state_q == ST_SCAN && chk_s1) begin
			if (mem_rdata.valid && mem_rdata.key == req_q.key) begin
				hit_idx_q <= idx_s1;
				hit_val_q <= mem_rdata.value;
			end
			if (!mem_rdata.valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
	end

	// One result per item, never back to back
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid |=> !response_valid)
		else $error("result strobe held for two cycles");

	// An accepted item makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// A refused insert never reports a present key
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid && response.status |-> !response.found)
		else $error("table-full status together with found");

endmodule

@@ rtl/kvt_mem.sv @@
// Entry memory of the key/value table: one write port, one read port,
// registered read data. Depends on kvt_pkg for the entry layout.
module kvt_mem import kvt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry, data in the next cycle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
